// File: rtl/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg
// Opcodes, operation classes, stage payload types and helper functions
// shared by the integer ALU pipeline.
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int DATA_W = 32;
    localparam int HALF_W = 16;
    localparam int ACT_W  = 4;
    localparam int SH_W   = 5;

    localparam logic [ACT_W-1:0] ACT_ADD    = 4'd0;
    localparam logic [ACT_W-1:0] ACT_SLL    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_SUBREV = 4'd2;
    localparam logic [ACT_W-1:0] ACT_CRADD  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_SUB    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_RSV    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_ANDNOT = 4'd6;
    localparam logic [ACT_W-1:0] ACT_CMP    = 4'd7;
    localparam logic [ACT_W-1:0] ACT_XOR    = 4'd8;
    localparam logic [ACT_W-1:0] ACT_ROR    = 4'd9;
    localparam logic [ACT_W-1:0] ACT_OR     = 4'd10;
    localparam logic [ACT_W-1:0] ACT_ROL    = 4'd11;
    localparam logic [ACT_W-1:0] ACT_SRL    = 4'd12;
    localparam logic [ACT_W-1:0] ACT_SRA    = 4'd13;
    localparam logic [ACT_W-1:0] ACT_AND    = 4'd14;
    localparam logic [ACT_W-1:0] ACT_BTST   = 4'd15;

    typedef enum logic [3:0] {
        OPC_ADD,
        OPC_SUB,
        OPC_CRADD,
        OPC_SLL,
        OPC_SRL,
        OPC_SRA,
        OPC_ROR,
        OPC_LOGIC,
        OPC_RSV
    } t_op_class;

    typedef enum logic [1:0] {
        LOG_AND,
        LOG_OR,
        LOG_XOR
    } t_logic_op;

    typedef struct packed {
        t_op_class          op_class;
        t_logic_op          logic_op;
        logic [DATA_W-1:0]  opd_a;
        logic [DATA_W-1:0]  opd_b;
        logic [SH_W-1:0]    shamt;
        logic               full_width;
        logic               carry_in;
        logic               ext_en;
        logic               mask_en;
        logic               write_en;
        logic               reserved;
        logic               rol;
    } t_dec;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic               carry;
        logic               overflow;
        logic               carry_in;
        logic               ext_en;
        logic               mask_en;
        logic               write_en;
        logic               reserved;
        logic               rol;
    } t_exe;

    function automatic logic [DATA_W-1:0] ext16(input logic [DATA_W-1:0] v);
        return {{(DATA_W-HALF_W){v[HALF_W-1]}}, v[HALF_W-1:0]};
    endfunction

    function automatic logic [DATA_W-1:0] rev32(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = v[DATA_W-1-i];
        end
        return r;
    endfunction

endpackage

// File: rtl/ialu_if.sv
// ----------------------------------------------------------------------------
// ialu_if
// Valid/ready channels for operation items entering the ALU and result
// items leaving it.
// ----------------------------------------------------------------------------
interface ialu_in_if;
    logic                              valid;
    logic                              ready;
    logic [ialu_pkg::ACT_W-1:0]        action;
    logic                              full_width;
    logic [ialu_pkg::DATA_W-1:0]       operand_s;
    logic [ialu_pkg::DATA_W-1:0]       operand_t;
    logic                              carry_in;

    modport source (
        output valid, action, full_width, operand_s, operand_t, carry_in,
        input  ready
    );
    modport sink (
        input  valid, action, full_width, operand_s, operand_t, carry_in,
        output ready
    );
endinterface

interface ialu_out_if;
    logic                              valid;
    logic                              ready;
    logic [ialu_pkg::DATA_W-1:0]       result_value;
    logic                              write_result;
    logic                              flag_negative;
    logic                              flag_zero;
    logic                              flag_carry;
    logic                              flag_overflow;
    logic                              reserved_op;

    modport source (
        output valid, result_value, write_result, flag_negative, flag_zero,
               flag_carry, flag_overflow, reserved_op,
        input  ready
    );
    modport sink (
        input  valid, result_value, write_result, flag_negative, flag_zero,
               flag_carry, flag_overflow, reserved_op,
        output ready
    );
endinterface

// File: rtl/dsp_integer_alu_16_32_core.sv
// ----------------------------------------------------------------------------
// dsp_integer_alu_16_32_core
// Integer ALU with N, Z, C and V flags, 16-bit and 32-bit modes.
// ----------------------------------------------------------------------------
// Takes one operation item per clock while the output is not stalled and
// returns one result item for each, in order. Items pass in turn through
// the three register stages: decode and operand preparation, the execute
// unit (adder, shifter, logic), and the flag and output register.
// Back-pressure on the output stalls the stages in turn; each stage takes
// a new item whenever it is empty or being emptied.
// ----------------------------------------------------------------------------
module dsp_integer_alu_16_32_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ialu_in_if.sink     i_in,
    ialu_out_if.source  o_res
);

    ialu_pkg::t_dec     dec;
    logic               dec_valid;
    logic               dec_ready;
    ialu_pkg::t_exe     exe;
    logic               exe_valid;
    logic               exe_ready;

    ialu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_dec   (dec),
        .o_valid (dec_valid),
        .i_ready (dec_ready)
    );

    ialu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dec   (dec),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .o_exe   (exe),
        .o_valid (exe_valid),
        .i_ready (exe_ready)
    );

    ialu_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exe   (exe),
        .i_valid (exe_valid),
        .o_ready (exe_ready),
        .o_res   (o_res)
    );

endmodule

// File: rtl/ialu_decode.sv
// ----------------------------------------------------------------------------
// ialu_decode
// First stage: decode the opcode into an operation class and prepare the
// operands (swap, reverse, width truncation, sign extension).
// ----------------------------------------------------------------------------
module ialu_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ialu_in_if.sink             i_in,
    output ialu_pkg::t_dec      o_dec,
    output logic                o_valid,
    input  logic                i_ready
);

    logic               r_valid;
    ialu_pkg::t_dec     r_dec;
    ialu_pkg::t_dec     n_dec;
    logic [ialu_pkg::DATA_W-1:0] s_trunc;

    assign i_in.ready = !r_valid || i_ready;
    assign s_trunc = i_in.full_width ? i_in.operand_s
                   : {{(ialu_pkg::DATA_W-ialu_pkg::HALF_W){1'b0}},
                      i_in.operand_s[ialu_pkg::HALF_W-1:0]};

    always_comb begin
        n_dec            = '0;
        n_dec.op_class   = ialu_pkg::OPC_LOGIC;
        n_dec.logic_op   = ialu_pkg::LOG_AND;
        n_dec.opd_a      = i_in.operand_s;
        n_dec.opd_b      = i_in.operand_t;
        n_dec.shamt      = i_in.operand_t[ialu_pkg::SH_W-1:0];
        n_dec.full_width = i_in.full_width;
        n_dec.carry_in   = i_in.carry_in;
        n_dec.ext_en     = !i_in.full_width;
        n_dec.write_en   = 1'b1;
        case (i_in.action)
            ialu_pkg::ACT_ADD: begin
                n_dec.op_class = ialu_pkg::OPC_ADD;
            end
            ialu_pkg::ACT_ROL: begin
                n_dec.op_class = ialu_pkg::OPC_ADD;
                n_dec.opd_b    = i_in.operand_s;
                n_dec.rol      = 1'b1;
            end
            ialu_pkg::ACT_SUB: begin
                n_dec.op_class = ialu_pkg::OPC_SUB;
            end
            ialu_pkg::ACT_CMP: begin
                n_dec.op_class = ialu_pkg::OPC_SUB;
                n_dec.write_en = 1'b0;
            end
            ialu_pkg::ACT_SUBREV: begin
                n_dec.op_class = ialu_pkg::OPC_SUB;
                n_dec.opd_a    = i_in.operand_t;
                n_dec.opd_b    = i_in.operand_s;
            end
            ialu_pkg::ACT_CRADD: begin
                n_dec.op_class = ialu_pkg::OPC_CRADD;
                n_dec.opd_a    = ialu_pkg::rev32(i_in.operand_s);
                n_dec.opd_b    = ialu_pkg::rev32(i_in.operand_t);
            end
            ialu_pkg::ACT_SLL: begin
                n_dec.op_class = ialu_pkg::OPC_SLL;
                n_dec.ext_en   = 1'b0;
                n_dec.mask_en  = !i_in.full_width;
            end
            ialu_pkg::ACT_SRL: begin
                n_dec.op_class = ialu_pkg::OPC_SRL;
                n_dec.opd_a    = s_trunc;
                n_dec.ext_en   = 1'b0;
            end
            ialu_pkg::ACT_SRA: begin
                n_dec.op_class = ialu_pkg::OPC_SRA;
                n_dec.opd_a    = i_in.full_width ? i_in.operand_s
                                                 : ialu_pkg::ext16(i_in.operand_s);
                n_dec.ext_en   = 1'b0;
            end
            ialu_pkg::ACT_ROR: begin
                n_dec.op_class = ialu_pkg::OPC_ROR;
                n_dec.opd_a    = s_trunc;
            end
            ialu_pkg::ACT_RSV: begin
                n_dec.op_class = ialu_pkg::OPC_RSV;
                n_dec.write_en = 1'b0;
                n_dec.reserved = 1'b1;
            end
            ialu_pkg::ACT_ANDNOT: begin
                n_dec.opd_b    = ~i_in.operand_t;
            end
            ialu_pkg::ACT_XOR: begin
                n_dec.logic_op = ialu_pkg::LOG_XOR;
            end
            ialu_pkg::ACT_OR: begin
                n_dec.logic_op = ialu_pkg::LOG_OR;
            end
            ialu_pkg::ACT_AND: begin
                n_dec.logic_op = ialu_pkg::LOG_AND;
            end
            ialu_pkg::ACT_BTST: begin
                n_dec.write_en = 1'b0;
            end
            default: begin
                n_dec.op_class = ialu_pkg::OPC_RSV;
                n_dec.write_en = 1'b0;
                n_dec.reserved = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_dec <= n_dec;
        end
    end

    assign o_dec   = r_dec;
    assign o_valid = r_valid;

endmodule

// File: rtl/ialu_exec.sv
// ----------------------------------------------------------------------------
// ialu_exec
// Second stage: add and subtract units, barrel shifter, rotate and logic
// unit; produces the raw value with carry and overflow.
// ----------------------------------------------------------------------------
module ialu_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ialu_pkg::t_dec      i_dec,
    input  logic                i_valid,
    output logic                o_ready,
    output ialu_pkg::t_exe      o_exe,
    output logic                o_valid,
    input  logic                i_ready
);

    localparam int DW = ialu_pkg::DATA_W;
    localparam int HW = ialu_pkg::HALF_W;

    logic               r_valid;
    ialu_pkg::t_exe     r_exe;
    ialu_pkg::t_exe     n_exe;
    logic [DW:0]        sum;
    logic [DW:0]        dif;
    logic               add_c16;
    logic               sub_b16;
    logic               a_top;
    logic               b_top;
    logic               sum_top;
    logic               dif_top;
    logic [DW-1:0]      a;
    logic [DW-1:0]      b;

    assign o_ready = !r_valid || i_ready;

    assign a       = i_dec.opd_a;
    assign b       = i_dec.opd_b;
    assign sum     = {1'b0, a} + {1'b0, b};
    assign dif     = {1'b0, a} - {1'b0, b};
    assign add_c16 = sum[HW] ^ a[HW] ^ b[HW];
    assign sub_b16 = dif[HW] ^ a[HW] ^ b[HW];
    assign a_top   = i_dec.full_width ? a[DW-1]   : a[HW-1];
    assign b_top   = i_dec.full_width ? b[DW-1]   : b[HW-1];
    assign sum_top = i_dec.full_width ? sum[DW-1] : sum[HW-1];
    assign dif_top = i_dec.full_width ? dif[DW-1] : dif[HW-1];

    always_comb begin
        n_exe          = '0;
        n_exe.carry_in = i_dec.carry_in;
        n_exe.ext_en   = i_dec.ext_en;
        n_exe.mask_en  = i_dec.mask_en;
        n_exe.write_en = i_dec.write_en;
        n_exe.reserved = i_dec.reserved;
        n_exe.rol      = i_dec.rol;
        case (i_dec.op_class)
            ialu_pkg::OPC_ADD: begin
                n_exe.value    = sum[DW-1:0];
                n_exe.carry    = i_dec.full_width ? sum[DW] : add_c16;
                n_exe.overflow = (a_top == b_top) && (a_top != sum_top);
            end
            ialu_pkg::OPC_SUB: begin
                n_exe.value    = dif[DW-1:0];
                n_exe.carry    = i_dec.full_width ? dif[DW] : sub_b16;
                n_exe.overflow = (a_top != b_top) && (a_top != dif_top);
            end
            ialu_pkg::OPC_CRADD: begin
                n_exe.value = ialu_pkg::rev32(sum[DW-1:0]);
                n_exe.carry = sum[DW];
            end
            ialu_pkg::OPC_SLL: begin
                n_exe.value = a << i_dec.shamt;
            end
            ialu_pkg::OPC_SRL: begin
                n_exe.value = a >> i_dec.shamt;
            end
            ialu_pkg::OPC_SRA: begin
                n_exe.value = DW'($signed(a) >>> i_dec.shamt);
            end
            ialu_pkg::OPC_ROR: begin
                n_exe.value = {1'b0, a[DW-1:1]};
                if (i_dec.full_width) begin
                    n_exe.value[DW-1] = i_dec.carry_in;
                end else begin
                    n_exe.value[HW-1] = i_dec.carry_in;
                end
                n_exe.carry = a[0];
            end
            ialu_pkg::OPC_LOGIC: begin
                case (i_dec.logic_op)
                    ialu_pkg::LOG_OR:  n_exe.value = a | b;
                    ialu_pkg::LOG_XOR: n_exe.value = a ^ b;
                    default:           n_exe.value = a & b;
                endcase
            end
            default: begin
                n_exe.value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_exe <= n_exe;
        end
    end

    assign o_exe   = r_exe;
    assign o_valid = r_valid;

endmodule

// File: rtl/ialu_flags.sv
// ----------------------------------------------------------------------------
// ialu_flags
// Third stage: width fix-up, rotate-left carry insertion, N and Z flags,
// write masking; holds the output register.
// ----------------------------------------------------------------------------
module ialu_flags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ialu_pkg::t_exe      i_exe,
    input  logic                i_valid,
    output logic                o_ready,
    ialu_out_if.source          o_res
);

    localparam int DW = ialu_pkg::DATA_W;
    localparam int HW = ialu_pkg::HALF_W;

    logic               r_valid;
    logic [DW-1:0]      r_result;
    logic               r_write;
    logic               r_neg;
    logic               r_zero;
    logic               r_carry;
    logic               r_ovf;
    logic               r_rsv;
    logic [DW-1:0]      n_val;
    logic [DW-1:0]      n_result;

    assign o_ready = !r_valid || o_res.ready;

    always_comb begin
        if (i_exe.ext_en) begin
            n_val = ialu_pkg::ext16(i_exe.value);
        end else if (i_exe.mask_en) begin
            n_val = {{(DW-HW){1'b0}}, i_exe.value[HW-1:0]};
        end else begin
            n_val = i_exe.value;
        end
        if (!i_exe.write_en) begin
            n_result = '0;
        end else if (i_exe.rol) begin
            n_result = n_val | {{(DW-1){1'b0}}, i_exe.carry_in};
        end else begin
            n_result = n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= n_result;
            r_write  <= i_exe.write_en;
            r_neg    <= !i_exe.reserved && n_val[DW-1];
            r_zero   <= !i_exe.reserved && (n_val == '0);
            r_carry  <= !i_exe.reserved && i_exe.carry;
            r_ovf    <= !i_exe.reserved && i_exe.overflow;
            r_rsv    <= i_exe.reserved;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.result_value  = r_result;
    assign o_res.write_result  = r_write;
    assign o_res.flag_negative = r_neg;
    assign o_res.flag_zero     = r_zero;
    assign o_res.flag_carry    = r_carry;
    assign o_res.flag_overflow = r_ovf;
    assign o_res.reserved_op   = r_rsv;

endmodule

// File: rtl/ialu_checker.sv
// ----------------------------------------------------------------------------
// ialu_checker
// Port-level checks on the integer ALU result channel.
// ----------------------------------------------------------------------------
module ialu_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_ready,
    input  logic [ialu_pkg::DATA_W-1:0]  i_result_value,
    input  logic                         i_write_result,
    input  logic                         i_flag_negative,
    input  logic                         i_flag_zero,
    input  logic                         i_flag_carry,
    input  logic                         i_flag_overflow,
    input  logic                         i_reserved_op
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_result_value))
        else $error("stalled result item changed");

    a_reserved_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_reserved_op |-> !i_write_result && !i_flag_negative &&
            !i_flag_zero && !i_flag_carry && !i_flag_overflow &&
            (i_result_value == '0))
        else $error("reserved item carries a result or flags");

    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_write_result |-> i_result_value == '0)
        else $error("unwritten result item is not zero");

    a_zero_not_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_flag_zero |-> !i_flag_negative)
        else $error("zero and negative flags both set");

endmodule

bind dsp_integer_alu_16_32_core ialu_checker u_ialu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_result_value  (o_res.result_value),
    .i_write_result  (o_res.write_result),
    .i_flag_negative (o_res.flag_negative),
    .i_flag_zero     (o_res.flag_zero),
    .i_flag_carry    (o_res.flag_carry),
    .i_flag_overflow (o_res.flag_overflow),
    .i_reserved_op   (o_res.reserved_op)
);
